// ===== hw/rtl/b32e_pkg.sv =====
// Shared types, constants and the symbol lookup for the base32 stream encoder.
// Used by b32e_front, b32e_queue, b32e_back and base32_stream_encoder_unit.
`default_nettype none

package b32e_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] BUF_SIZE_RESET = 16'hFFFF;
  localparam logic [6:0]  PAD_CHAR       = 7'h3D;
  localparam logic [6:0]  NUL_CHAR       = 7'h00;

  // First character sits in the top byte.
  localparam logic [255:0] ALPHABET = "0123456789ABCDEFGHJKLMNPQRSTUVXY";

  // Up to three symbol indexes per byte: two full groups plus the padded tail.
  typedef struct packed {
    logic [2:0][4:0] syms;
    logic [1:0]      count;
    logic            last;
  } b32e_entry_t;

  typedef enum logic {
    ST_SYM,
    ST_PAD
  } b32e_state_t;

  function automatic logic [6:0] sym_char(input logic [4:0] idx);
    logic [7:0] c;
    c = ALPHABET[{~idx, 3'b000} +: 8];
    return c[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/base32_stream_encoder_unit.sv =====
// Top level of the base32 stream encoder: config register, front end, queue, sequencer.
// Depends on b32e_pkg, b32e_front, b32e_queue and b32e_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata[7:0] byte_value, tlast last_byte
//  out_    | out | out_tvalid/out_tready| tdata[6:0] out_char, tlast last_char,
//          |     |                      | tuser overflow_error
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data[15:0] buffer_size (always ready)
//
// Cycles: the sequencer issues at most one beat per cycle while the output is not stalled:
// a symbol, a '=' or the terminator. A byte takes one step per 5-bit group (dropped
// groups still take their step); a last byte also takes its '=' padding and terminator.
// The front end packs a byte in the cycle it is accepted and never waits on the
// sequencer unless the queue is full; the output register decouples out_tready.
// Reset clears bit buffer, counters, queue and output valid; buffer_size returns
// to 65535. No clearing pass.
`default_nettype none

module base32_stream_encoder_unit #(
  parameter int COUNT_BITS  = b32e_pkg::COUNT_BITS,
  parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] byte_value
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  // out_tdata: [6:0] out_char, [7] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  // out_tuser: [0] overflow_error
  output logic             out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] buffer_size_r;

  logic                  fq_valid, fq_ready;
  b32e_pkg::b32e_entry_t fq_entry;
  logic                  qb_valid, qb_ready;
  b32e_pkg::b32e_entry_t qb_entry;
  logic [6:0]            char_w;

  // Capacity register: the user must write it only between messages; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= b32e_pkg::BUF_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buffer_size_r <= cfg_data;
    end
  end

  // Pack bytes into 5-bit groups as they arrive.
  b32e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_valid  (fq_valid),
    .q_entry  (fq_entry),
    .q_ready  (fq_ready)
  );

  // Hold packed groups until the sequencer can walk them.
  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_entry  (fq_entry),
    .in_ready  (fq_ready),
    .out_valid (qb_valid),
    .out_entry (qb_entry),
    .out_ready (qb_ready)
  );

  // Emit characters, padding and the terminator beat, one per cycle unless the output stalls.
  b32e_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .buffer_size (buffer_size_r),
    .q_valid     (qb_valid),
    .q_entry     (qb_entry),
    .q_ready     (qb_ready),
    .out_valid   (out_tvalid),
    .out_char    (char_w),
    .out_last    (out_tlast),
    .out_err     (out_tuser),
    .out_ready   (out_tready)
  );

  assign out_tdata = {1'b0, char_w};

endmodule

`default_nettype wire

// ===== hw/rtl/b32e_front.sv =====
// Front end: accepts bytes, packs bits MSB-first and splits them into 5-bit groups.
// Depends on b32e_pkg for the queue entry type.
`default_nettype none

module b32e_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   in_ready,
  output logic                   q_valid,
  output b32e_pkg::b32e_entry_t  q_entry,
  input  wire logic              q_ready
);

  logic [11:0] bit_buffer_r, bit_buffer_nxt;
  logic [3:0]  bits_held_r, bits_held_nxt;

  logic [11:0] buf_w, shr0, shr1, shl_t;
  logic [3:0]  bh0, bh1, bh2, bh3;
  logic        two, tail;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;

  always_comb begin
    bh0   = (bits_held_r > 4'd4) ? 4'd4 : bits_held_r;
    buf_w = {bit_buffer_r[3:0], in_byte};
    bh1   = bh0 + 4'd8;
    shr0  = buf_w >> (bh1 - 4'd5);
    bh2   = bh1 - 4'd5;
    two   = (bh2 >= 4'd5);
    shr1  = buf_w >> (bh2 - 4'd5);
    bh3   = two ? (bh2 - 4'd5) : bh2;
    tail  = in_last && (bh3 != 4'd0);
    shl_t = buf_w << (4'd5 - bh3);

    q_entry.syms[0] = shr0[4:0];
    q_entry.syms[1] = two ? shr1[4:0] : shl_t[4:0];
    q_entry.syms[2] = shl_t[4:0];
    q_entry.count   = 2'd1 + {1'b0, two} + {1'b0, tail};
    q_entry.last    = in_last;

    if (in_last) begin
      bit_buffer_nxt = '0;
      bits_held_nxt  = '0;
    end else begin
      bit_buffer_nxt = buf_w;
      bits_held_nxt  = bh3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_buffer_r <= '0;
      bits_held_r  <= '0;
    end else if (in_valid && q_ready) begin
      bit_buffer_r <= bit_buffer_nxt;
      bits_held_r  <= bits_held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b32e_queue.sv =====
// Short FIFO of symbol-group entries between the front end and the sequencer.
// Depends on b32e_pkg for the entry type.
`default_nettype none

module b32e_queue #(
  parameter int DEPTH = b32e_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  b32e_pkg::b32e_entry_t  in_entry,
  output logic                   in_ready,
  output logic                   out_valid,
  output b32e_pkg::b32e_entry_t  out_entry,
  input  wire logic              out_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b32e_pkg::b32e_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign in_ready  = (count_r != CNT_W'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_entry = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_ready && out_valid;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b32e_back.sv =====
// Back end: walks queue entries, emits symbols, '=' padding and the terminator beat.
// Depends on b32e_pkg for the entry type, state enum and symbol lookup.
`default_nettype none

module b32e_back #(
  parameter int COUNT_BITS = b32e_pkg::COUNT_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       buffer_size,
  input  wire logic              q_valid,
  input  b32e_pkg::b32e_entry_t  q_entry,
  output logic                   q_ready,
  output logic                   out_valid,
  output logic [6:0]             out_char,
  output logic                   out_last,
  output logic                   out_err,
  input  wire logic              out_ready
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  b32e_pkg::b32e_state_t state_r, state_nxt;
  logic [1:0]            sel_r, sel_nxt;
  logic [COUNT_BITS-1:0] cw_r, cw_nxt;
  logic [2:0]            gp_r, gp_nxt;
  logic                  out_valid_r, out_last_r, out_err_r;
  logic [6:0]            out_char_r;

  logic       advance, room, emit, bump, clear;
  logic [6:0] ch;
  logic       lst, err;
  logic [4:0] sym;

  assign advance   = !out_valid_r || out_ready;
  assign room      = CMP_W'(cw_r) < CMP_W'(buffer_size);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

  always_comb begin
    case (sel_r)
      2'd1:    sym = q_entry.syms[1];
      2'd2:    sym = q_entry.syms[2];
      default: sym = q_entry.syms[0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    q_ready   = 1'b0;
    emit      = 1'b0;
    bump      = 1'b0;
    clear     = 1'b0;
    ch        = b32e_pkg::NUL_CHAR;
    lst       = 1'b0;
    err       = 1'b0;
    if (advance && q_valid) begin
      unique case (state_r)
        b32e_pkg::ST_SYM: begin
          if (sel_r < q_entry.count && room) begin
            emit = 1'b1;
            bump = 1'b1;
            ch   = b32e_pkg::sym_char(sym);
          end
          if (({1'b0, sel_r} + 3'd1) >= {1'b0, q_entry.count}) begin
            sel_nxt = '0;
            if (q_entry.last) state_nxt = b32e_pkg::ST_PAD;
            else              q_ready   = 1'b1;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end
        b32e_pkg::ST_PAD: begin
          emit = 1'b1;
          if (gp_r != 3'd0 && room) begin
            bump = 1'b1;
            ch   = b32e_pkg::PAD_CHAR;
          end else begin
            lst       = 1'b1;
            err       = !room;
            clear     = 1'b1;
            q_ready   = 1'b1;
            state_nxt = b32e_pkg::ST_SYM;
          end
        end
        default: state_nxt = b32e_pkg::ST_SYM;
      endcase
    end

    cw_nxt = cw_r;
    gp_nxt = gp_r;
    if (clear) begin
      cw_nxt = '0;
      gp_nxt = '0;
    end else if (bump) begin
      cw_nxt = (cw_r == CNT_MAX) ? cw_r : cw_r + COUNT_BITS'(1);
      gp_nxt = gp_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b32e_pkg::ST_SYM;
      sel_r       <= '0;
      cw_r        <= '0;
      gp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cw_r    <= cw_nxt;
      gp_r    <= gp_nxt;
      if (advance) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_char_r <= ch;
      out_last_r <= lst;
      out_err_r  <= err;
    end
  end

  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && state_r == b32e_pkg::ST_SYM) |-> (sel_r < q_entry.count))
    else $error("symbol select beyond entry count");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && q_valid && state_r == b32e_pkg::ST_PAD && !(gp_r != 3'd0 && room))
      |=> (cw_r == '0 && gp_r == 3'd0 && state_r == b32e_pkg::ST_SYM))
    else $error("terminator did not clear message state");

  a_group_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cw_r != CNT_MAX) |-> (gp_r == cw_r[2:0]))
    else $error("group position out of step with character count");

endmodule

`default_nettype wire
